FILE: design/trrb_pkg.sv
// package: constants, opcodes and point type of the trajectory record/replay buffer
`timescale 1ns / 1ps
package trrb_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 11;
  localparam int COORD_W     = 16;
  localparam int THR_W       = 16;
  localparam int OP_W        = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int MIN_CLOSED  = 3;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

  // opcodes
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_RECORD  = 3'd1;
  localparam logic [OP_W-1:0] OP_REPLAY  = 3'd2;
  localparam logic [OP_W-1:0] OP_REW_FWD = 3'd3;
  localparam logic [OP_W-1:0] OP_REW_REV = 3'd4;

  // configuration register indexes
  localparam logic CFG_LENGTH    = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0] LENGTH_RESET    = 11'd1024;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd300;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage

FILE: design/trajectory_record_replay_buffer_top.sv
// top level: point store in one synchronous ram, cursor and end control, status logic
// sequence: the accepting edge of start enters S_EXEC, then S_FIN follows, where done is high;
//   the store access (one write or one registered read) is made in S_EXEC, the result shown in S_FIN
// throughput: no new transaction is taken while one executes (busy); start is taken again while done shows
// reset (rst, synchronous): control, cursor, end, copies and config take reset values;
//   the point store is not cleared, only entries below the end are ever read
`timescale 1ns / 1ps
module trajectory_record_replay_buffer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [trrb_pkg::OP_W-1:0]           opcode,
  input  logic signed [trrb_pkg::COORD_W-1:0] point_x,
  input  logic signed [trrb_pkg::COORD_W-1:0] point_y,
  input  logic signed [trrb_pkg::COORD_W-1:0] point_z,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [trrb_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                done,
  output logic                                point_valid,
  output logic signed [trrb_pkg::COORD_W-1:0] out_x,
  output logic signed [trrb_pkg::COORD_W-1:0] out_y,
  output logic signed [trrb_pkg::COORD_W-1:0] out_z,
  output logic                                record_accepted,
  output logic                                has_next,
  output logic                                closed_loop,
  output logic [trrb_pkg::CNT_W-1:0]          point_count
);
  import trrb_pkg::*;

  state_t state;
  state_t state_next;

  // configuration
  logic [CNT_W-1:0] length_in_use;
  logic [THR_W-1:0] closing_dist;

  // latched transaction
  logic [OP_W-1:0] op_q;
  point_t          pt_q;

  // control state
  logic [CNT_W-1:0] cursor;
  logic [CNT_W-1:0] valid_end;
  logic             reverse_mode;
  point_t           first_copy;
  point_t           last_copy;

  // per-transaction flags
  logic got;
  logic accepted;

  // memory
  point_t            mem [STORE_DEPTH];
  point_t            rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  // execute-cycle decode
  logic [CNT_W-1:0] end_lim;
  logic             rec_ok;
  logic             fwd_ok;
  logic             rev_ok;
  logic [CNT_W-1:0] cursor_dec;

  logic in_accept;

  assign in_accept = start && !busy;
  assign busy      = (state == S_EXEC);
  assign done      = (state == S_FIN);

  assign end_lim    = (length_in_use > DEPTH_CNT) ? DEPTH_CNT : length_in_use;
  assign cursor_dec = cursor - CNT_W'(1);
  assign rec_ok     = (cursor < end_lim);
  assign fwd_ok     = !reverse_mode && (cursor < valid_end);
  assign rev_ok     = reverse_mode && (cursor != '0);
  assign wr_en      = (state == S_EXEC) && (op_q == OP_RECORD) && rec_ok;
  assign rd_addr    = reverse_mode ? cursor_dec[ADDR_W-1:0] : cursor[ADDR_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC:  state_next = S_FIN;
      S_FIN:   state_next = start ? S_EXEC : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use <= LENGTH_RESET;
      closing_dist  <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LENGTH:    length_in_use <= cfg_data[CNT_W-1:0];
        CFG_THRESHOLD: closing_dist  <= cfg_data[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  // capture transaction payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q   <= opcode;
      pt_q.x <= point_x;
      pt_q.y <= point_y;
      pt_q.z <= point_z;
    end
  end

  // point store: one write or one registered read per transaction
  always_ff @(posedge clk) begin
    if (wr_en) mem[cursor[ADDR_W-1:0]] <= pt_q;
    rd_data <= mem[rd_addr];
  end

  // cursor, end, mode and endpoint copies
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor       <= '0;
      valid_end    <= '0;
      reverse_mode <= 1'b0;
      first_copy   <= '0;
      last_copy    <= '0;
      got          <= 1'b0;
      accepted     <= 1'b0;
    end else if (state == S_EXEC) begin
      got      <= (op_q == OP_REPLAY) && (rev_ok || fwd_ok);
      accepted <= (op_q == OP_RECORD) && rec_ok;
      unique case (op_q)
        OP_CLEAR: begin
          cursor       <= '0;
          valid_end    <= '0;
          reverse_mode <= 1'b0;
        end
        OP_RECORD: begin
          if (rec_ok) begin
            if (cursor == '0) first_copy <= pt_q;
            last_copy <= pt_q;
            cursor    <= cursor + CNT_W'(1);
            valid_end <= cursor + CNT_W'(1);
          end
        end
        OP_REPLAY: begin
          if (rev_ok)      cursor <= cursor_dec;
          else if (fwd_ok) cursor <= cursor + CNT_W'(1);
        end
        OP_REW_FWD: cursor <= '0;
        OP_REW_REV: begin
          reverse_mode <= 1'b1;
          cursor       <= valid_end;
        end
        default: ;
      endcase
    end
  end

  // closed-path test on the endpoint copies
  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic signed [COORD_W:0] dz;
  logic [COORD_W:0]        ax;
  logic [COORD_W:0]        ay;
  logic [COORD_W:0]        az;
  logic [COORD_W:0]        thr_ext;

  assign dx      = (COORD_W+1)'(first_copy.x) - (COORD_W+1)'(last_copy.x);
  assign dy      = (COORD_W+1)'(first_copy.y) - (COORD_W+1)'(last_copy.y);
  assign dz      = (COORD_W+1)'(first_copy.z) - (COORD_W+1)'(last_copy.z);
  assign ax      = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
  assign ay      = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
  assign az      = dz[COORD_W] ? (COORD_W+1)'(-dz) : (COORD_W+1)'(dz);
  assign thr_ext = {1'b0, closing_dist};

  // result outputs
  assign point_valid     = got;
  assign out_x           = got ? rd_data.x : '0;
  assign out_y           = got ? rd_data.y : '0;
  assign out_z           = got ? rd_data.z : '0;
  assign record_accepted = accepted;
  assign has_next        = reverse_mode ? (cursor != '0) : (cursor < valid_end);
  assign closed_loop     = (valid_end >= CNT_W'(MIN_CLOSED)) &&
                           (ax < thr_ext) && (ay < thr_ext) && (az < thr_ext);
  assign point_count     = valid_end;

`ifndef SYNTHESIS
  // a result follows only an execute cycle
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding execute cycle");

  // the cursor never passes the valid end
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= valid_end)
    else $error("cursor beyond valid end");

  // valid end stays within the store
  a_end_in_store: assert property (@(posedge clk) disable iff (rst)
    valid_end <= DEPTH_CNT)
    else $error("valid end beyond store depth");

  // a transaction cannot both replay and record
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(point_valid && record_accepted))
    else $error("replay and record flagged together");
`endif

endmodule

FILE: sim/tb_trajectory_record_replay_buffer_top.sv
// testbench: random and directed command traffic into the trajectory buffer, checked by a scoreboard
`timescale 1ns / 1ps
module tb_trajectory_record_replay_buffer_top;
  import trrb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;

  // one expected or observed result
  typedef struct {
    logic             valid;
    point_t           pt;
    logic             accepted;
    logic             has_next;
    logic             closed;
    logic [CNT_W-1:0] count;
  } buffer_result_t;

  // predicts buffer status per command and checks it against the block
  class trajectory_scoreboard;
    point_t           store [STORE_DEPTH];
    logic [CNT_W-1:0] cursor;
    logic [CNT_W-1:0] path_end;
    logic [CNT_W-1:0] length_reg;
    logic [THR_W-1:0] thresh_reg;
    logic             reverse;
    point_t           first_pt;
    point_t           last_pt;
    buffer_result_t   pending_status [$];
    int               errors;
    int               checked;
    int               recorded;
    int               refused;
    int               replayed;
    int               closed_hits;

    function new();
      cursor = '0;
      path_end = '0;
      reverse = 1'b0;
      first_pt = '0;
      last_pt = '0;
      length_reg = LENGTH_RESET;
      thresh_reg = THRESHOLD_RESET;
      errors = 0;
      checked = 0;
      recorded = 0;
      refused = 0;
      replayed = 0;
      closed_hits = 0;
    endfunction

    function void apply_reg(logic idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_LENGTH) length_reg = val[CNT_W-1:0];
      else thresh_reg = val[THR_W-1:0];
    endfunction

    // at least three points and first/last within threshold on every axis
    function logic closed_path();
      int dx, dy, dz;
      if (path_end < CNT_W'(MIN_CLOSED)) return 1'b0;
      dx = int'($signed(first_pt.x)) - int'($signed(last_pt.x));
      dy = int'($signed(first_pt.y)) - int'($signed(last_pt.y));
      dz = int'($signed(first_pt.z)) - int'($signed(last_pt.z));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      return (dx < int'(thresh_reg)) && (dy < int'(thresh_reg)) && (dz < int'(thresh_reg));
    endfunction

    // accepted command transaction: update buffer state, queue the status
    function void note_command(logic [OP_W-1:0] op, point_t p);
      buffer_result_t   r;
      logic [CNT_W-1:0] lim;
      r.valid = 1'b0;
      r.pt = '0;
      r.accepted = 1'b0;
      lim = (length_reg > DEPTH_CNT) ? DEPTH_CNT : length_reg;
      case (op)
        OP_CLEAR: begin
          cursor = '0;
          path_end = '0;
          reverse = 1'b0;
        end
        OP_RECORD: begin
          if (cursor < lim) begin
            store[int'(cursor)] = p;
            if (cursor == 0) first_pt = p;
            last_pt = p;
            cursor = cursor + CNT_W'(1);
            path_end = cursor;
            r.accepted = 1'b1;
            recorded++;
          end else begin
            refused++;
          end
        end
        OP_REPLAY: begin
          if (reverse) begin
            if (cursor != 0) begin
              cursor = cursor - CNT_W'(1);
              r.pt = store[int'(cursor)];
              r.valid = 1'b1;
            end
          end else if (cursor < path_end) begin
            r.pt = store[int'(cursor)];
            r.valid = 1'b1;
            cursor = cursor + CNT_W'(1);
          end
          if (r.valid) replayed++;
        end
        OP_REW_FWD: cursor = '0;
        OP_REW_REV: begin
          reverse = 1'b1;
          cursor = path_end;
        end
        default: ;
      endcase
      r.has_next = reverse ? (cursor != 0) : (cursor < path_end);
      r.closed = closed_path();
      r.count = path_end;
      if (r.closed) closed_hits++;
      pending_status.push_back(r);
    endfunction

    task report_mismatch(string what, logic [15:0] exp_v, logic [15:0] got_v);
      $display("mismatch on result %0d, %s: expected 'h%0h, got 'h%0h",
               checked, what, exp_v, got_v);
      errors++;
    endtask

    task check_field(string what, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) report_mismatch(what, exp_v, got_v);
    endtask

    task check_result(buffer_result_t got);
      buffer_result_t e;
      if (pending_status.size() == 0) begin
        report_mismatch("result with no command pending", 16'd0, 16'd1);
        return;
      end
      e = pending_status.pop_front();
      check_field("point_valid", 16'(e.valid), 16'(got.valid));
      check_field("out_x", e.pt.x, got.pt.x);
      check_field("out_y", e.pt.y, got.pt.y);
      check_field("out_z", e.pt.z, got.pt.z);
      check_field("record_accepted", 16'(e.accepted), 16'(got.accepted));
      check_field("has_next", 16'(e.has_next), 16'(got.has_next));
      check_field("closed_loop", 16'(e.closed), 16'(got.closed));
      check_field("point_count", 16'(e.count), 16'(got.count));
      checked++;
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         opcode = OP_CLEAR;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic                    cfg_we = 1'b0;
  logic                    cfg_index = CFG_LENGTH;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    done;
  logic                    point_valid;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                    record_accepted;
  logic                    has_next;
  logic                    closed_loop;
  logic [CNT_W-1:0]        point_count;

  trajectory_scoreboard sb = new();
  int             idle_pct = 0;
  int             stall_cycles = 0;
  int             settings_run = 0;
  point_t         anchor = '0;
  buffer_result_t seen;

  trajectory_record_replay_buffer_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .point_valid(point_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .record_accepted(record_accepted), .has_next(has_next), .closed_loop(closed_loop),
    .point_count(point_count)
  );

  always #10 clk = ~clk;

  // result monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        seen.valid = point_valid;
        seen.pt.x = out_x;
        seen.pt.y = out_y;
        seen.pt.z = out_z;
        seen.accepted = record_accepted;
        seen.has_next = has_next;
        seen.closed = closed_loop;
        seen.count = point_count;
        sb.check_result(seen);
      end
      if (done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic point_t mk_pt(int x, int y, int z);
    point_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.z = 16'(z);
    return p;
  endfunction

  // one command transaction, with random sender gaps before it
  task automatic send_cmd(logic [OP_W-1:0] op, point_t p);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    point_x <= p.x;
    point_y <= p.y;
    point_z <= p.z;
    do @(posedge clk); while (busy);
    sb.note_command(op, p);
  endtask

  // stop sending and wait until every result is back
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(logic idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.apply_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random commands with given opcode weights in percent; the rest are reserved opcodes
  task automatic run_random(int n, int w_clr, int w_rec, int w_rep, int w_rwf, int w_rwr);
    int              r;
    logic [OP_W-1:0] op;
    point_t          p;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < w_clr) op = OP_CLEAR;
      else if (r < w_clr + w_rec) op = OP_RECORD;
      else if (r < w_clr + w_rec + w_rep) op = OP_REPLAY;
      else if (r < w_clr + w_rec + w_rep + w_rwf) op = OP_REW_FWD;
      else if (r < w_clr + w_rec + w_rep + w_rwf + w_rwr) op = OP_REW_REV;
      else op = OP_REW_REV + 3'($urandom_range(3, 1));
      // half the points near the anchor so paths can close
      if ($urandom_range(1) == 1) begin
        p = point_t'(48'({$urandom, $urandom}));
      end else begin
        p.x = anchor.x + 16'($urandom_range(800)) - 16'd400;
        p.y = anchor.y + 16'($urandom_range(800)) - 16'd400;
        p.z = anchor.z + 16'($urandom_range(800)) - 16'd400;
      end
      if (op == OP_CLEAR) anchor = point_t'(48'({$urandom, $urandom}));
      send_cmd(op, p);
    end
  endtask

  // new register setting between phases, then random traffic
  task automatic run_setting(logic [CNT_W-1:0] len, logic [THR_W-1:0] thr, int idle,
                             bit fresh, int n, int w_clr, int w_rec, int w_rep,
                             int w_rwf, int w_rwr);
    settle();
    program_reg(CFG_LENGTH, CFG_DATA_W'(len));
    program_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    idle_pct = idle;
    settings_run++;
    if (fresh) send_cmd(OP_CLEAR, '0);
    run_random(n, w_clr, w_rec, w_rep, w_rwf, w_rwr);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset register values, empty store, reserved opcodes
    idle_pct = 27;
    send_cmd(OP_REPLAY, '0);
    for (int k = 1; k <= 3; k++) send_cmd(OP_REW_REV + 3'(k), mk_pt(-1, 21845, -21846));
    // coordinate extremes, then closing exactly inside and at the threshold
    send_cmd(OP_RECORD, mk_pt(-32768, 32767, 0));
    send_cmd(OP_RECORD, mk_pt(32767, -32768, -1));
    send_cmd(OP_RECORD, mk_pt(0, 0, 0));
    send_cmd(OP_RECORD, mk_pt(-32768 + 299, 32767 - 299, 299));
    send_cmd(OP_RECORD, mk_pt(-32768 + 300, 32767, 0));
    send_cmd(OP_REPLAY, '0);
    send_cmd(OP_REPLAY, '0);
    // reverse replay from the end down past slot zero
    send_cmd(OP_REW_REV, '0);
    for (int k = 0; k < 6; k++) send_cmd(OP_REPLAY, '0);
    // forward rewind keeps reverse mode
    send_cmd(OP_REW_FWD, '0);
    send_cmd(OP_REPLAY, '0);
    send_cmd(OP_REW_REV, '0);
    send_cmd(OP_REPLAY, '0);
    // record mid-path truncates the end
    send_cmd(OP_RECORD, mk_pt(100, 200, 300));
    send_cmd(OP_REW_FWD, '0);
    send_cmd(OP_RECORD, mk_pt(-5, 5, -5));
    send_cmd(OP_CLEAR, '0);
    send_cmd(OP_REPLAY, '0);

    // sender idles 27 percent of cycles
    run_setting(11'd1024, 16'd300, 27, 1'b0, 60, 3, 40, 35, 9, 9);
    run_setting(11'd5, 16'd300, 27, 1'b0, 40, 5, 45, 30, 8, 8);
    run_setting(11'd0, 16'd1000, 27, 1'b0, 20, 5, 45, 30, 8, 8);
    // sender idles 49 percent: fill past the store depth with an oversize length
    run_setting(11'd2047, 16'd65535, 49, 1'b1, 1060, 0, 100, 0, 0, 0);
    // length lowered below the cursor, recorded points stay replayable
    run_setting(11'd10, 16'd65535, 49, 1'b0, 50, 0, 30, 40, 12, 12);
    run_setting(11'($urandom_range(40, 3)), 16'($urandom), 49, 1'b0, 50, 3, 45, 35, 7, 7);
    // no sender gaps
    run_setting(11'd1024, 16'd0, 0, 1'b0, 40, 3, 45, 35, 7, 7);
    run_setting(11'd1, 16'd300, 0, 1'b0, 20, 5, 45, 30, 8, 8);
    run_setting(11'd1025, 16'd300, 0, 1'b1, 40, 3, 45, 35, 7, 7);

    settle();
    $display("checked %0d results over %0d register settings: %0d points recorded, %0d refused",
             sb.checked, settings_run, sb.recorded, sb.refused);
    $display("%0d points replayed, %0d results with a closed path, reserved opcodes included",
             sb.replayed, sb.closed_hits);
    if (sb.errors == 0 && sb.pending_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
